// File: design/cltb_pkg.sv
// cltb_pkg: shared constants and codes for the character lcd text buffer
// depends on: nothing
`timescale 1ns / 1ps

package cltb_pkg;

  // store geometry: cell (r, c) sits at address r * MAX_COLUMNS + c
  localparam int MAX_ROWS    = 4;
  localparam int MAX_COLUMNS = 32;
  localparam int ROW_W       = $clog2(MAX_ROWS);
  localparam int COL_W       = $clog2(MAX_COLUMNS);
  localparam int ADDR_W      = ROW_W + COL_W;
  localparam int CELL_COUNT  = MAX_ROWS * MAX_COLUMNS;

  // field widths
  localparam int CHAR_W     = 7;
  localparam int CODE_W     = 8;
  localparam int OP_W       = 4;
  localparam int ROWS_CNT_W = 3;
  localparam int COLS_CNT_W = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  // character handling
  localparam logic [CHAR_W-1:0] SPACE_CODE     = 7'h20;
  localparam logic [CODE_W-1:0] LOW_PRINTABLE  = 8'd32;
  localparam logic [CODE_W-1:0] HIGH_PRINTABLE = 8'd126;

  // configuration reset values
  localparam logic [ROWS_CNT_W-1:0] ROW_COUNT_RST    = 3'd2;
  localparam logic [COLS_CNT_W-1:0] COLUMN_COUNT_RST = 6'd16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 2'd1;

  // command codes
  localparam logic [OP_W-1:0] OP_WRITE     = 4'd0;
  localparam logic [OP_W-1:0] OP_CLEAR     = 4'd1;
  localparam logic [OP_W-1:0] OP_CLEAR_EOL = 4'd2;
  localparam logic [OP_W-1:0] OP_UP        = 4'd3;
  localparam logic [OP_W-1:0] OP_DOWN      = 4'd4;
  localparam logic [OP_W-1:0] OP_LEFT      = 4'd5;
  localparam logic [OP_W-1:0] OP_RIGHT     = 4'd6;
  localparam logic [OP_W-1:0] OP_SET_POS   = 4'd7;
  localparam logic [OP_W-1:0] OP_READ      = 4'd8;

endpackage

// File: design/cltb_ram.sv
// cltb_ram: generic single-write, single-read ram with registered read data
// depends on: nothing
`timescale 1ns / 1ps

module cltb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: design/char_lcd_text_buffer.sv
// char_lcd_text_buffer: character display text store with a cursor
// result: registered in the cycle after acceptance, except read cell, which waits in ST_READ for ram data
// throughput: one command per cycle while the result channel is not stalled; no new command during the read wait
// reset (synchronous, rst_n low): cursor 0,0, all cells read as space, 2 rows x 16 cols
// clear and clear-to-eol act on all affected per-cell valid flops at once, no clearing pass
// depends on: cltb_pkg, cltb_ram
`timescale 1ns / 1ps

module char_lcd_text_buffer (
  input  logic                             clk,
  input  logic                             rst_n,
  // command channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [cltb_pkg::OP_W-1:0]        in_opcode,
  input  logic [cltb_pkg::CODE_W-1:0]      in_char_code,
  input  logic [cltb_pkg::ROW_W-1:0]       in_target_row,
  input  logic [cltb_pkg::COL_W-1:0]       in_target_column,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_ok,
  output logic [cltb_pkg::ROW_W-1:0]       out_cursor_row,
  output logic [cltb_pkg::COL_W-1:0]       out_cursor_column,
  output logic [cltb_pkg::CHAR_W-1:0]      out_cell_char,
  // configuration write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [cltb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cltb_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import cltb_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [ROWS_CNT_W-1:0] row_count_r;
  logic [COLS_CNT_W-1:0] column_count_r;

  // cursor and cell valid flags (a cell not valid reads as space)
  logic [ROW_W-1:0]      cursor_row_r, cursor_row_nxt;
  logic [COL_W-1:0]      cursor_col_r, cursor_col_nxt;
  logic [CELL_COUNT-1:0] valid_r, valid_nxt;

  // result register
  logic              out_valid_r, out_valid_nxt;
  logic              out_ok_r, out_ok_nxt;
  logic [ROW_W-1:0]  out_row_r, out_row_nxt;
  logic [COL_W-1:0]  out_col_r, out_col_nxt;
  logic [CHAR_W-1:0] out_cell_r, out_cell_nxt;

  // pending read: ok means in range, vld means the cell was written
  logic rd_ok_r, rd_ok_nxt;
  logic rd_vld_r, rd_vld_nxt;

  // ram side
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CHAR_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CHAR_W-1:0] ram_rdata;

  // effective area and saturated cursor
  logic [ROWS_CNT_W-1:0] rows_used;
  logic [COLS_CNT_W-1:0] cols_used;
  logic [ROW_W-1:0]      cur_row;
  logic [COL_W-1:0]      cur_col;
  logic                  row_can_inc;
  logic                  col_can_inc;
  logic                  target_in;
  logic [CODE_W-1:0]     wr_code;

  logic in_accept;
  logic out_free;

  assign cfg_ready = 1'b1;

  // the result register can take a new transaction when empty or draining now
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == ST_IDLE) && out_free);
  assign in_accept = in_valid && !in_stall;

  assign out_valid         = out_valid_r;
  assign out_ok            = out_ok_r;
  assign out_cursor_row    = out_row_r;
  assign out_cursor_column = out_col_r;
  assign out_cell_char     = out_cell_r;

  // a zero count acts as 1, a count above the maximum saturates
  always_comb begin
    if (row_count_r == '0) begin
      rows_used = ROWS_CNT_W'(1);
    end else if (row_count_r > ROWS_CNT_W'(MAX_ROWS)) begin
      rows_used = ROWS_CNT_W'(MAX_ROWS);
    end else begin
      rows_used = row_count_r;
    end
    if (column_count_r == '0) begin
      cols_used = COLS_CNT_W'(1);
    end else if (column_count_r > COLS_CNT_W'(MAX_COLUMNS)) begin
      cols_used = COLS_CNT_W'(MAX_COLUMNS);
    end else begin
      cols_used = column_count_r;
    end
  end

  // cursor pulled back into a shrunk area before each command
  always_comb begin
    if (ROWS_CNT_W'(cursor_row_r) >= rows_used) begin
      cur_row = ROW_W'(rows_used - ROWS_CNT_W'(1));
    end else begin
      cur_row = cursor_row_r;
    end
    if (COLS_CNT_W'(cursor_col_r) >= cols_used) begin
      cur_col = COL_W'(cols_used - COLS_CNT_W'(1));
    end else begin
      cur_col = cursor_col_r;
    end
  end

  assign row_can_inc = (ROWS_CNT_W'(cur_row) + ROWS_CNT_W'(1)) < rows_used;
  assign col_can_inc = (COLS_CNT_W'(cur_col) + COLS_CNT_W'(1)) < cols_used;
  assign target_in   = (ROWS_CNT_W'(in_target_row) < rows_used) &&
                       (COLS_CNT_W'(in_target_column) < cols_used);

  // non-printable codes are stored as space
  assign wr_code = ((in_char_code < LOW_PRINTABLE) || (in_char_code > HIGH_PRINTABLE)) ?
                   CODE_W'(SPACE_CODE) : in_char_code;

  assign ram_we    = in_accept && (in_opcode == OP_WRITE);
  assign ram_waddr = {cur_row, cur_col};
  assign ram_wdata = wr_code[CHAR_W-1:0];
  assign ram_re    = in_accept && (in_opcode == OP_READ);
  assign ram_raddr = {in_target_row, in_target_column};

  cltb_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (CELL_COUNT)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // command decode and next state
  always_comb begin
    logic [ADDR_W-1:0] a;
    state_nxt      = state_r;
    cursor_row_nxt = cursor_row_r;
    cursor_col_nxt = cursor_col_r;
    valid_nxt      = valid_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_ok_nxt     = out_ok_r;
    out_row_nxt    = out_row_r;
    out_col_nxt    = out_col_r;
    out_cell_nxt   = out_cell_r;
    rd_ok_nxt      = rd_ok_r;
    rd_vld_nxt     = rd_vld_r;
    a              = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          cursor_row_nxt = cur_row;
          cursor_col_nxt = cur_col;
          out_ok_nxt     = 1'b0;
          out_cell_nxt   = '0;
          out_valid_nxt  = 1'b1;

          unique case (in_opcode)
            OP_WRITE: begin
              valid_nxt[ram_waddr] = 1'b1;
              out_ok_nxt = 1'b1;
              if (col_can_inc) begin
                cursor_col_nxt = cur_col + COL_W'(1);
              end else if (row_can_inc) begin
                cursor_row_nxt = cur_row + ROW_W'(1);
                cursor_col_nxt = '0;
              end else begin
                cursor_row_nxt = '0;
                cursor_col_nxt = '0;
              end
            end
            OP_CLEAR: begin
              valid_nxt      = '0;
              cursor_row_nxt = '0;
              cursor_col_nxt = '0;
              out_ok_nxt     = 1'b1;
            end
            OP_CLEAR_EOL: begin
              // blank the cursor row from the cursor through the last used column
              for (int i = 0; i < CELL_COUNT; i++) begin
                a = ADDR_W'(i);
                if ((a[ADDR_W-1:COL_W] == cur_row) && (a[COL_W-1:0] >= cur_col) &&
                    (COLS_CNT_W'(a[COL_W-1:0]) < cols_used)) begin
                  valid_nxt[i] = 1'b0;
                end
              end
              out_ok_nxt = 1'b1;
            end
            OP_UP: begin
              if (cur_row != '0) begin
                cursor_row_nxt = cur_row - ROW_W'(1);
                out_ok_nxt     = 1'b1;
              end
            end
            OP_DOWN: begin
              if (row_can_inc) begin
                cursor_row_nxt = cur_row + ROW_W'(1);
                out_ok_nxt     = 1'b1;
              end
            end
            OP_LEFT: begin
              if (cur_col != '0) begin
                cursor_col_nxt = cur_col - COL_W'(1);
                out_ok_nxt     = 1'b1;
              end
            end
            OP_RIGHT: begin
              if (col_can_inc) begin
                cursor_col_nxt = cur_col + COL_W'(1);
                out_ok_nxt     = 1'b1;
              end
            end
            OP_SET_POS: begin
              if (target_in) begin
                cursor_row_nxt = in_target_row;
                cursor_col_nxt = in_target_column;
                out_ok_nxt     = 1'b1;
              end
            end
            OP_READ: begin
              // result waits in the read wait state for the ram read data
              out_valid_nxt = 1'b0;
              out_ok_nxt    = target_in;
              rd_ok_nxt     = target_in;
              rd_vld_nxt    = valid_r[ram_raddr];
              state_nxt     = ST_READ;
            end
            default: begin
              // unknown command: no change, ok stays low
            end
          endcase

          out_row_nxt = cursor_row_nxt;
          out_col_nxt = cursor_col_nxt;
        end
      end
      ST_READ: begin
        // result register is empty here, it was free at acceptance
        out_valid_nxt = 1'b1;
        if (!rd_ok_r) begin
          out_cell_nxt = '0;
        end else if (rd_vld_r) begin
          out_cell_nxt = ram_rdata;
        end else begin
          out_cell_nxt = SPACE_CODE;
        end
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state, cursor, valid flags, pending read, configuration and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      cursor_row_r   <= '0;
      cursor_col_r   <= '0;
      valid_r        <= '0;
      out_valid_r    <= 1'b0;
      rd_ok_r        <= 1'b0;
      rd_vld_r       <= 1'b0;
      row_count_r    <= ROW_COUNT_RST;
      column_count_r <= COLUMN_COUNT_RST;
    end else begin
      state_r      <= state_nxt;
      cursor_row_r <= cursor_row_nxt;
      cursor_col_r <= cursor_col_nxt;
      valid_r      <= valid_nxt;
      out_valid_r  <= out_valid_nxt;
      rd_ok_r      <= rd_ok_nxt;
      rd_vld_r     <= rd_vld_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_ROW_COUNT) begin
          row_count_r <= cfg_data[ROWS_CNT_W-1:0];
        end else if (cfg_index == CFG_COLUMN_COUNT) begin
          column_count_r <= cfg_data[COLS_CNT_W-1:0];
        end
      end
    end
    out_ok_r   <= out_ok_nxt;
    out_row_r  <= out_row_nxt;
    out_col_r  <= out_col_nxt;
    out_cell_r <= out_cell_nxt;
  end

`ifndef SYNTHESIS
  // the read wait state only runs with an empty result register
  a_read_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |-> !out_valid_r)
    else $error("result register busy during read wait");

  // an accepted read cell always goes through the read wait
  a_read_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (in_opcode == OP_READ)) |=> (state_r == ST_READ))
    else $error("read cell skipped the ram wait");

  // a failed command never reports a character
  a_fail_no_char: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ok_r) |-> (out_cell_r == '0))
    else $error("character reported on a failed command");

  // clear drops every written cell at once
  a_clear_all: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (in_opcode == OP_CLEAR)) |=> (valid_r == '0))
    else $error("cells left valid after clear");
`endif

endmodule
